// File: rtl/iou_gdm_pkg.sv
// Shared constants and codes for the greedy IoU detection matcher.
// Used by the matcher top level; its RAM and multiplier submodules do not use it.
package iou_gdm_pkg;

  localparam int unsigned MaxDetections = 64;
  localparam int unsigned CoordBits     = 12;
  localparam int unsigned LabelBits     = 4;
  localparam int unsigned CountBits     = 24;

  localparam int unsigned OpBits       = 2;
  localparam int unsigned CfgIndexBits = 2;
  localparam int unsigned CfgDataBits  = 12;
  localparam int unsigned ThrBits      = 9;
  localparam int unsigned MinWidthBits = 12;
  localparam logic [ThrBits-1:0] ThrReset = 9'd128;

  typedef enum logic [OpBits-1:0] {
    OP_LOAD  = 2'd0,
    OP_MATCH = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_MIN_WIDTH = 2'd1,
    CFG_LABEL_CHK = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_index_e;

endpackage

// File: rtl/iou_gdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iou_gdm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/iou_gdm_mul.sv
// Shared unsigned multiplier with a registered product.
// Operands are selected by the matcher sequencer; no package dependencies.
module iou_gdm_mul #(
  parameter int unsigned OpWidth = 25
) (
  input  logic                   clk_i,
  input  logic [OpWidth-1:0]     a_i,
  input  logic [OpWidth-1:0]     b_i,
  output logic [2*OpWidth-1:0]   p_o
);

  logic [2*OpWidth-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: rtl/iou_greedy_detection_matcher.sv
// Greedy IoU matcher top level: sequencer, detection table and counters.
// Depends on iou_gdm_pkg, iou_gdm_ram and iou_gdm_mul.
//
// Usage:
//   A request is taken when start is high and busy is low. op selects:
//   load a detection (left/right/top/bottom/class_label) into the table,
//   match a ground-truth box against the unused detections, or end the image.
//   A load returns nothing and leaves busy low; a full table drops the load
//   and sets the sticky overflowed flag. A match or end-of-image request
//   returns one result, shown for exactly one cycle with result_valid_o high,
//   in the first cycle with busy low again. The receiver cannot stall; results
//   must be taken when shown.
//   A match keeps busy high while the shared multiplier forms the ground-truth
//   area and the table RAM is read one entry at a time: an entry that is used
//   or does not overlap is skipped, one whose union is zero is dropped after
//   the intersection and area products, and each other entry also gets both
//   cross-multiplied IoU products; the threshold product comes last. The one
//   multiplier does all of these in turn. End of image keeps busy high for
//   one table read per loaded detection.
//   Configuration writes go through cfg_valid_i/cfg_index_i/cfg_data_i and
//   are always ready; write them only while the block is idle.
//   Reset empties the table, clears counters and the overflow flag, and
//   loads the default registers; the table RAM needs no clearing pass.
module iou_greedy_detection_matcher #(
  parameter int unsigned MaxDets  = iou_gdm_pkg::MaxDetections,
  parameter int unsigned CoordW   = iou_gdm_pkg::CoordBits,
  parameter int unsigned LabelW   = iou_gdm_pkg::LabelBits,
  parameter int unsigned CountW   = iou_gdm_pkg::CountBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [iou_gdm_pkg::OpBits-1:0]        op_i,
  input  logic [CoordW-1:0]                     left_i,
  input  logic [CoordW-1:0]                     right_i,
  input  logic [CoordW-1:0]                     top_i,
  input  logic [CoordW-1:0]                     bottom_i,
  input  logic [LabelW-1:0]                     class_label_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [iou_gdm_pkg::CfgIndexBits-1:0]  cfg_index_i,
  input  logic [iou_gdm_pkg::CfgDataBits-1:0]   cfg_data_i,
  output logic                                  result_valid_o,
  output logic                                  matched_o,
  output logic [$clog2(MaxDets)-1:0]            match_index_o,
  output logic [CountW-1:0]                     tp_count_o,
  output logic [CountW-1:0]                     fp_count_o,
  output logic [CountW-1:0]                     fn_count_o,
  output logic                                  overflowed_o
);

  import iou_gdm_pkg::*;

  localparam int unsigned IdxW  = $clog2(MaxDets);
  localparam int unsigned CntW  = $clog2(MaxDets + 1);
  localparam int unsigned AreaW = 2 * CoordW;
  localparam int unsigned MulW  = 2 * CoordW + 1;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned EntW  = 4 * CoordW + LabelW;
  localparam int unsigned SumW  = (CountW > CntW ? CountW : CntW) + 1;
  localparam int unsigned WcmpW = (CoordW > MinWidthBits ? CoordW : MinWidthBits);
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_GTA  = 17'h00002,
    S_GTW  = 17'h00004,
    S_RD   = 17'h00008,
    S_DAT  = 17'h00010,
    S_MI   = 17'h00020,
    S_MA   = 17'h00040,
    S_UN   = 17'h00080,
    S_C1   = 17'h00100,
    S_C2   = 17'h00200,
    S_C3   = 17'h00400,
    S_THR  = 17'h00800,
    S_TC   = 17'h01000,
    S_FIN  = 17'h02000,
    S_ERD  = 17'h04000,
    S_EDAT = 17'h08000,
    S_EFIN = 17'h10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [ThrBits-1:0]      thr_q;
  logic [MinWidthBits-1:0] min_width_q;
  logic                    label_chk_q;

  // Control and counters
  logic [CntW-1:0]   det_count_q;
  logic [IdxW-1:0]   idx_q;
  logic [CntW-1:0]   unused_q;
  logic [CountW-1:0] tp_q, fp_q, fn_q;
  logic              drop_q;
  logic              found_q;
  logic              result_valid_q;
  logic              matched_q;
  logic [IdxW-1:0]   match_index_q;

  // Datapath registers (no reset)
  logic [CoordW-1:0] gl_q, gr_q, gt_q, gb_q;
  logic [LabelW-1:0] glab_q;
  logic [AreaW-1:0]  gta_q;
  logic [CoordW-1:0] iw_q, ih_q, dw_q, dh_q;
  logic [LabelW-1:0] cur_lab_q, best_lab_q;
  logic [AreaW-1:0]  in_q, best_in_q;
  logic [MulW-1:0]   uu_q, best_un_q;
  logic [ProdW-1:0]  p1_q;
  logic [IdxW-1:0]   best_idx_q;

  // RAM ports
  logic              box_we, used_we, used_wdata;
  logic [IdxW-1:0]   waddr;
  logic [EntW-1:0]   box_wdata, box_rdata;
  logic              used_rdata;

  // Multiplier
  logic [MulW-1:0]   mul_a, mul_b;
  logic [ProdW-1:0]  mul_p;

  logic accept;
  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Table fields of the entry just read
  logic [CoordW-1:0] dl, dr, dt, db;
  logic [LabelW-1:0] dlab;
  assign {dl, dr, dt, db, dlab} = box_rdata;

  // Intersection extents, signed by one extra bit
  logic [CoordW-1:0] xmin_r, xmax_l, ymin_b, ymax_t;
  logic [CoordW:0]   iw_s, ih_s;
  assign xmin_r = (gr_q < dr) ? gr_q : dr;
  assign xmax_l = (gl_q > dl) ? gl_q : dl;
  assign ymin_b = (gb_q < db) ? gb_q : db;
  assign ymax_t = (gt_q > dt) ? gt_q : dt;
  assign iw_s   = {1'b0, xmin_r} - {1'b0, xmax_l};
  assign ih_s   = {1'b0, ymin_b} - {1'b0, ymax_t};

  logic [CoordW:0] gw_s;
  assign gw_s = {1'b0, gr_q} - {1'b0, gl_q};

  logic wide_enough;
  assign wide_enough = !gw_s[CoordW] &&
    (WcmpW'(gw_s[CoordW-1:0]) > WcmpW'(min_width_q));

  logic [MulW-1:0] union_v;
  assign union_v = MulW'(gta_q) + MulW'(mul_p[AreaW-1:0]) - MulW'(in_q);

  logic last;
  assign last = ((CntW'(idx_q) + CntW'(1)) == det_count_q);

  logic [SumW-1:0] fp_sum;
  assign fp_sum = SumW'(fp_q) + SumW'(unused_q);

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_GTA: begin
        mul_a = MulW'(gw_s[CoordW-1:0]);
        mul_b = MulW'(gb_q - gt_q);
      end
      S_MI: begin
        mul_a = MulW'(iw_q);
        mul_b = MulW'(ih_q);
      end
      S_MA: begin
        mul_a = MulW'(dw_q);
        mul_b = MulW'(dh_q);
      end
      S_C1: begin
        mul_a = MulW'(in_q);
        mul_b = best_un_q;
      end
      S_C2: begin
        mul_a = MulW'(best_in_q);
        mul_b = uu_q;
      end
      S_THR: begin
        mul_a = best_un_q;
        mul_b = MulW'(thr_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Table writes: loads in idle, used mark on an accepted match
  always_comb begin
    box_we     = 1'b0;
    used_we    = 1'b0;
    used_wdata = 1'b0;
    waddr      = det_count_q[IdxW-1:0];
    box_wdata  = {left_i, right_i, top_i, bottom_i, class_label_i};
    if (accept && (op_i == OP_LOAD) && (det_count_q < CntW'(MaxDets))) begin
      box_we  = 1'b1;
      used_we = 1'b1;
    end else if ((state_q == S_FIN) && found_q) begin
      used_we    = 1'b1;
      used_wdata = 1'b1;
      waddr      = best_idx_q;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (op_i == OP_MATCH)) begin
          state_d = S_GTA;
        end else if (accept && (op_i == OP_END)) begin
          state_d = (det_count_q == '0) ? S_EFIN : S_ERD;
        end
      end
      S_GTA:  state_d = S_GTW;
      S_GTW:  state_d = (det_count_q == '0) ? S_THR : S_RD;
      S_RD:   state_d = S_DAT;
      S_DAT: begin
        if (used_rdata || iw_s[CoordW] || ih_s[CoordW]) begin
          state_d = last ? S_THR : S_RD;
        end else begin
          state_d = S_MI;
        end
      end
      S_MI:   state_d = S_MA;
      S_MA:   state_d = S_UN;
      S_UN: begin
        if (union_v == '0) begin
          state_d = last ? S_THR : S_RD;
        end else begin
          state_d = S_C1;
        end
      end
      S_C1:   state_d = S_C2;
      S_C2:   state_d = S_C3;
      S_C3:   state_d = last ? S_THR : S_RD;
      S_THR:  state_d = found_q ? S_TC : S_FIN;
      S_TC:   state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      S_ERD:  state_d = S_EDAT;
      S_EDAT: state_d = last ? S_EFIN : S_ERD;
      S_EFIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, counters and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      thr_q          <= ThrReset;
      min_width_q    <= '0;
      label_chk_q    <= 1'b0;
      det_count_q    <= '0;
      idx_q          <= '0;
      unused_q       <= '0;
      tp_q           <= '0;
      fp_q           <= '0;
      fn_q           <= '0;
      drop_q         <= 1'b0;
      found_q        <= 1'b0;
      result_valid_q <= 1'b0;
      matched_q      <= 1'b0;
      match_index_q  <= '0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= 1'b0;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD: thr_q       <= cfg_data_i[ThrBits-1:0];
          CFG_MIN_WIDTH: min_width_q <= cfg_data_i[MinWidthBits-1:0];
          CFG_LABEL_CHK: label_chk_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          idx_q    <= '0;
          unused_q <= '0;
          found_q  <= 1'b0;
          if (accept && (op_i == OP_LOAD)) begin
            if (det_count_q < CntW'(MaxDets)) begin
              det_count_q <= det_count_q + CntW'(1);
            end else begin
              drop_q <= 1'b1;
            end
          end
        end
        S_DAT: begin
          if (used_rdata || iw_s[CoordW] || ih_s[CoordW]) begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        S_UN: begin
          if (union_v == '0) begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        S_C3: begin
          // Only a strictly larger IoU replaces the best: earliest index wins ties
          if (p1_q > mul_p) begin
            found_q <= 1'b1;
          end
          idx_q <= idx_q + IdxW'(1);
        end
        S_TC: begin
          if ((ProdW'({best_in_q, 8'b0}) < mul_p) ||
              (label_chk_q && (best_lab_q != glab_q))) begin
            found_q <= 1'b0;
          end
        end
        S_FIN: begin
          result_valid_q <= 1'b1;
          matched_q      <= found_q;
          match_index_q  <= found_q ? best_idx_q : '0;
          if (found_q) begin
            if (wide_enough && (tp_q != CountMax)) begin
              tp_q <= tp_q + CountW'(1);
            end
          end else if (fn_q != CountMax) begin
            fn_q <= fn_q + CountW'(1);
          end
        end
        S_EDAT: begin
          if (!used_rdata) begin
            unused_q <= unused_q + CntW'(1);
          end
          idx_q <= idx_q + IdxW'(1);
        end
        S_EFIN: begin
          result_valid_q <= 1'b1;
          matched_q      <= 1'b0;
          match_index_q  <= '0;
          fp_q           <= (fp_sum > SumW'(CountMax)) ? CountMax : fp_sum[CountW-1:0];
          det_count_q    <= '0;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      gl_q   <= left_i;
      gr_q   <= right_i;
      gt_q   <= top_i;
      gb_q   <= bottom_i;
      glab_q <= class_label_i;
      best_in_q <= '0;
      best_un_q <= MulW'(1);
    end
    case (state_q)
      S_GTW: gta_q <= mul_p[AreaW-1:0];
      S_DAT: begin
        iw_q      <= iw_s[CoordW-1:0];
        ih_q      <= ih_s[CoordW-1:0];
        dw_q      <= dr - dl;
        dh_q      <= db - dt;
        cur_lab_q <= dlab;
      end
      S_MA:  in_q <= mul_p[AreaW-1:0];
      S_UN:  uu_q <= union_v;
      S_C2:  p1_q <= mul_p;
      S_C3: begin
        if (p1_q > mul_p) begin
          best_in_q  <= in_q;
          best_un_q  <= uu_q;
          best_idx_q <= idx_q;
          best_lab_q <= cur_lab_q;
        end
      end
      default: ;
    endcase
  end

  iou_gdm_ram #(
    .Width (EntW),
    .Depth (MaxDets)
  ) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (box_we),
    .waddr_i (waddr),
    .wdata_i (box_wdata),
    .raddr_i (idx_q),
    .rdata_o (box_rdata)
  );

  iou_gdm_ram #(
    .Width (1),
    .Depth (MaxDets)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (waddr),
    .wdata_i (used_wdata),
    .raddr_i (idx_q),
    .rdata_o (used_rdata)
  );

  iou_gdm_mul #(
    .OpWidth (MulW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign result_valid_o = result_valid_q;
  assign matched_o      = matched_q;
  assign match_index_o  = match_index_q;
  assign tp_count_o     = tp_q;
  assign fp_count_o     = fp_q;
  assign fn_count_o     = fn_q;
  assign overflowed_o   = drop_q;

  a_single_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |=> !result_valid_q)
    else $error("result strobe held for more than one cycle");

  a_table_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    det_count_q <= CntW'(MaxDets))
    else $error("detection count beyond table depth");

  a_match_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && matched_q) |-> (CntW'(match_index_q) < det_count_q))
    else $error("matched index outside the loaded table");

  a_drop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(drop_q))
    else $error("overflow flag cleared without reset");

endmodule
